/* src/hsv_to_rgb_converter_macros.svh */
// Assertion macros for the HSV to RGB converter.
// Included by the RTL files that carry concurrent checks; needs i_clk and i_rst_n in scope.
`ifndef HSV_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define H2R_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define H2R_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/hsv2rgb_pkg.sv */
// Shared types, constants and helpers for the HSV to RGB converter.
// No dependencies; used by every module of the block.
package hsv2rgb_pkg;

    localparam int SAT_MAX_DEF = 255;

    localparam int HUE_W    = 16;
    localparam int FRAC_W   = 13;
    localparam int CHAN_W   = 8;
    localparam int PROD_W   = 2 * CHAN_W;
    localparam int RAMP_W   = FRAC_W + CHAN_W;
    localparam int COLOR_W  = 3 * CHAN_W;

    localparam logic [HUE_W-1:0]  HUE_SECTOR = 16'd7680;
    localparam logic [HUE_W-1:0]  HUE_LIMIT  = 16'd46080;
    localparam logic [FRAC_W-1:0] FRAC_FULL  = 13'd7680;

    // x / 7680 == (x >> 9) / 15, and y / 15 == (y * 4370) >> 16 for y < 3840
    localparam int SECTOR_SHIFT = 9;
    localparam int DIV15_MUL_W  = 13;
    localparam logic [DIV15_MUL_W-1:0] DIV15_MUL = 13'd4370;
    localparam int DIV15_SHIFT  = 16;

    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = RECIP_SHIFT + 1;

    localparam logic [2:0] SEC_R2Y = 3'd0;
    localparam logic [2:0] SEC_Y2G = 3'd1;
    localparam logic [2:0] SEC_G2C = 3'd2;
    localparam logic [2:0] SEC_C2B = 3'd3;
    localparam logic [2:0] SEC_B2M = 3'd4;
    localparam logic [2:0] SEC_M2R = 3'd5;

    typedef struct packed {
        logic              oor;
        logic [2:0]        sector;
        logic [FRAC_W-1:0] frac;
        logic [CHAN_W-1:0] maxc;
    } t_side;

    function automatic logic [HUE_W-1:0] sector_base(input logic [2:0] sector);
        logic [HUE_W-1:0] base;
        begin
            unique case (sector)
                SEC_R2Y: base = 16'd0;
                SEC_Y2G: base = 16'd7680;
                SEC_G2C: base = 16'd15360;
                SEC_C2B: base = 16'd23040;
                SEC_B2M: base = 16'd30720;
                default: base = 16'd38400;
            endcase
            return base;
        end
    endfunction

endpackage

/* src/hsv2rgb_span.sv */
// Chroma span pipeline: clamp saturation, multiply by value, divide by SAT_MAX.
// Three register stages; division by reciprocal multiply with one correction.
// Depends on hsv2rgb_pkg.
module hsv2rgb_span #(
    parameter int SAT_MAX = hsv2rgb_pkg::SAT_MAX_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [hsv2rgb_pkg::CHAN_W-1:0]    i_sat,
    input  hsv2rgb_pkg::t_side                i_side,
    output logic                              o_valid,
    output logic [hsv2rgb_pkg::CHAN_W-1:0]    o_span,
    output hsv2rgb_pkg::t_side                o_side
);

    localparam int CW = hsv2rgb_pkg::CHAN_W;
    localparam int PW = hsv2rgb_pkg::PROD_W;
    localparam int RW = hsv2rgb_pkg::RECIP_W;
    localparam int RS = hsv2rgb_pkg::RECIP_SHIFT;
    localparam logic [CW-1:0] SatMaxW  = CW'(SAT_MAX);
    localparam logic [RW-1:0] SatRecip = RW'((1 << RS) / SAT_MAX);

    logic                r1_valid, r2_valid, r3_valid;
    logic [PW-1:0]       r1_prod, r2_prod;
    logic [CW-1:0]       r2_qe, r3_span;
    hsv2rgb_pkg::t_side  r1_side, r2_side, r3_side;

    logic [CW-1:0]       n1_sat;
    logic [PW+RW-1:0]    n2_full;
    logic [PW-1:0]       n3_back;
    logic [PW-1:0]       n3_rem;
    logic [CW-1:0]       n3_span;

    always_comb begin
        n1_sat  = (i_sat > SatMaxW) ? SatMaxW : i_sat;
        n2_full = (PW+RW)'(r1_prod) * (PW+RW)'(SatRecip);
        n3_back = PW'(r2_qe) * PW'(SatMaxW);
        n3_rem  = r2_prod - n3_back;
        n3_span = (n3_rem >= PW'(SatMaxW)) ? (r2_qe + CW'(1)) : r2_qe;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_prod <= PW'(n1_sat) * PW'(i_side.maxc);
        r1_side <= i_side;
        r2_qe   <= n2_full[RS +: CW];
        r2_prod <= r1_prod;
        r2_side <= r1_side;
        r3_span <= n3_span;
        r3_side <= r2_side;
    end

    assign o_valid = r3_valid;
    assign o_span  = r3_span;
    assign o_side  = r3_side;

endmodule

/* src/hsv2rgb_ramp.sv */
// Ramp and channel select: interpolate the moving channel and pack the color.
// Two register stages; division by 7680 as a shift and a reciprocal multiply.
// Depends on hsv2rgb_pkg.
module hsv2rgb_ramp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [hsv2rgb_pkg::CHAN_W-1:0]    i_span,
    input  hsv2rgb_pkg::t_side                i_side,
    output logic                              o_valid,
    output logic [hsv2rgb_pkg::COLOR_W-1:0]   o_color,
    output logic                              o_oor
);

    localparam int CW  = hsv2rgb_pkg::CHAN_W;
    localparam int FW  = hsv2rgb_pkg::FRAC_W;
    localparam int AW  = hsv2rgb_pkg::RAMP_W;
    localparam int SS  = hsv2rgb_pkg::SECTOR_SHIFT;
    localparam int YW  = AW - SS;
    localparam int MW  = hsv2rgb_pkg::DIV15_MUL_W;
    localparam int DS  = hsv2rgb_pkg::DIV15_SHIFT;

    logic            r1_valid, r2_valid;
    logic [AW-1:0]   r1_up_prod, r1_dn_prod;
    logic [CW-1:0]   r1_min, r1_max;
    logic [2:0]      r1_sector;
    logic            r1_oor;
    logic [3*CW-1:0] r2_color;
    logic            r2_oor;

    logic [FW-1:0]   n1_rest;
    logic [YW+MW-1:0] n2_up_full, n2_dn_full;
    logic [CW-1:0]   n2_up, n2_dn;
    logic [3*CW-1:0] n2_color;

    always_comb begin
        n1_rest    = hsv2rgb_pkg::FRAC_FULL - i_side.frac;
        n2_up_full = (YW+MW)'(r1_up_prod[AW-1:SS]) * (YW+MW)'(hsv2rgb_pkg::DIV15_MUL);
        n2_dn_full = (YW+MW)'(r1_dn_prod[AW-1:SS]) * (YW+MW)'(hsv2rgb_pkg::DIV15_MUL);
        n2_up      = r1_min + n2_up_full[DS +: CW];
        n2_dn      = r1_min + n2_dn_full[DS +: CW];
        unique case (r1_sector)
            hsv2rgb_pkg::SEC_R2Y: n2_color = {r1_max, n2_up,  r1_min};
            hsv2rgb_pkg::SEC_Y2G: n2_color = {n2_dn,  r1_max, r1_min};
            hsv2rgb_pkg::SEC_G2C: n2_color = {r1_min, r1_max, n2_up};
            hsv2rgb_pkg::SEC_C2B: n2_color = {r1_min, n2_dn,  r1_max};
            hsv2rgb_pkg::SEC_B2M: n2_color = {n2_up,  r1_min, r1_max};
            default:              n2_color = {r1_max, r1_min, n2_dn};
        endcase
        if (r1_oor) begin
            n2_color = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_up_prod <= AW'(i_side.frac) * AW'(i_span);
        r1_dn_prod <= AW'(n1_rest) * AW'(i_span);
        r1_min     <= i_side.maxc - i_span;
        r1_max     <= i_side.maxc;
        r1_sector  <= i_side.sector;
        r1_oor     <= i_side.oor;
        r2_color   <= n2_color;
        r2_oor     <= r1_oor;
    end

    assign o_valid = r2_valid;
    assign o_color = r2_color;
    assign o_oor   = r2_oor;

endmodule

/* src/hsv_to_rgb_converter.sv */
// HSV to RGB converter top level: hue decode feeding the span and ramp pipelines.
// An accepted start passes the span stages, then the ramp stages, to the o_valid strobe; one word per cycle.
// busy is high only during reset and in the cycle after it; the output cannot stall.
// Synchronous active-low reset clears all valid bits; no word is in flight after it.
// Depends on hsv2rgb_pkg, hsv2rgb_span, hsv2rgb_ramp and the assertion macro header.
`include "hsv_to_rgb_converter_macros.svh"
module hsv_to_rgb_converter #(
    parameter int SAT_MAX = hsv2rgb_pkg::SAT_MAX_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [hsv2rgb_pkg::HUE_W-1:0]     i_hue,
    input  logic [hsv2rgb_pkg::CHAN_W-1:0]    i_saturation,
    input  logic [hsv2rgb_pkg::CHAN_W-1:0]    i_brightness,
    output logic                              o_valid,
    output logic [hsv2rgb_pkg::COLOR_W-1:0]   o_color,
    output logic                              o_hue_out_of_range
);

    localparam int HW = hsv2rgb_pkg::HUE_W;
    localparam int FW = hsv2rgb_pkg::FRAC_W;
    localparam int CW = hsv2rgb_pkg::CHAN_W;

    logic               r_busy;
    logic               n_accept;
    logic [2:0]         n_sector;
    hsv2rgb_pkg::t_side n_side;
    logic               span_valid;
    logic [CW-1:0]      span_value;
    hsv2rgb_pkg::t_side span_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy     = r_busy;
    assign n_accept = start && !r_busy;

    always_comb begin
        priority if (i_hue < HW'(1 * hsv2rgb_pkg::HUE_SECTOR)) begin
            n_sector = hsv2rgb_pkg::SEC_R2Y;
        end else if (i_hue < HW'(2 * hsv2rgb_pkg::HUE_SECTOR)) begin
            n_sector = hsv2rgb_pkg::SEC_Y2G;
        end else if (i_hue < HW'(3 * hsv2rgb_pkg::HUE_SECTOR)) begin
            n_sector = hsv2rgb_pkg::SEC_G2C;
        end else if (i_hue < HW'(4 * hsv2rgb_pkg::HUE_SECTOR)) begin
            n_sector = hsv2rgb_pkg::SEC_C2B;
        end else if (i_hue < HW'(5 * hsv2rgb_pkg::HUE_SECTOR)) begin
            n_sector = hsv2rgb_pkg::SEC_B2M;
        end else begin
            n_sector = hsv2rgb_pkg::SEC_M2R;
        end
        n_side.oor    = (i_hue >= hsv2rgb_pkg::HUE_LIMIT);
        n_side.sector = n_sector;
        n_side.frac   = FW'(i_hue - hsv2rgb_pkg::sector_base(n_sector));
        n_side.maxc   = i_brightness;
    end

    hsv2rgb_span #(
        .SAT_MAX (SAT_MAX)
    ) u_span (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (n_accept),
        .i_sat   (i_saturation),
        .i_side  (n_side),
        .o_valid (span_valid),
        .o_span  (span_value),
        .o_side  (span_side)
    );

    hsv2rgb_ramp u_ramp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (span_valid),
        .i_span  (span_value),
        .i_side  (span_side),
        .o_valid (o_valid),
        .o_color (o_color),
        .o_oor   (o_hue_out_of_range)
    );

    `H2R_ASSERT_CLK(a_latency, n_accept |-> ##5 o_valid, "accepted word missing at output")
    `H2R_ASSERT_CLK(a_no_orphan, o_valid |-> $past(n_accept, 5), "output word without input")
    `H2R_ASSERT_CLK(a_oor_black, (o_valid && o_hue_out_of_range) |-> (o_color == '0), "out-of-range hue not black")
    `H2R_ASSERT_NEXT(a_span_le_max, span_valid, $past(span_value) <= $past(span_side.maxc), "span exceeds value")

endmodule

/* test/tb_hsv_to_rgb_converter.sv */
`timescale 1ns / 1ps
// Testbench for hsv_to_rgb_converter: directed and random pixels, each result checked.
// Holds its own color predictor in a small scoreboard class; depends on hsv2rgb_pkg and the converter under test.
module tb_hsv_to_rgb_converter;

    localparam int unsigned SAT_MAX    = hsv2rgb_pkg::SAT_MAX_DEF;
    localparam int          HUE_W      = hsv2rgb_pkg::HUE_W;
    localparam int          CHAN_W     = hsv2rgb_pkg::CHAN_W;
    localparam int          COLOR_W    = hsv2rgb_pkg::COLOR_W;
    localparam logic [HUE_W-1:0] HUE_SECTOR = hsv2rgb_pkg::HUE_SECTOR;
    localparam logic [HUE_W-1:0] HUE_LIMIT  = hsv2rgb_pkg::HUE_LIMIT;
    localparam int          WATCHDOG   = 2000;
    localparam int          DRAIN_WAIT = 10;
    localparam int          PHASE_LEN  = 407;

    typedef struct {
        logic [COLOR_W-1:0] color;
        logic               oor;
    } t_rgb_word;

    class rgb_scoreboard;
        t_rgb_word pending[$];
        int        errors;

        function void note_pixel(logic [HUE_W-1:0] hue, logic [CHAN_W-1:0] sat,
                                 logic [CHAN_W-1:0] val);
            t_rgb_word   w;
            int unsigned s, maxc, span, minc, frac, up, down;
            logic [2:0]  sector;
            logic [CHAN_W-1:0] r, g, b;
            w.oor   = (hue >= HUE_LIMIT);
            w.color = '0;
            if (!w.oor) begin
                s      = (sat > SAT_MAX) ? SAT_MAX : sat;
                maxc   = val;
                span   = (s * maxc) / SAT_MAX;
                minc   = maxc - span;
                sector = 3'(hue / HUE_SECTOR);
                frac   = hue % HUE_SECTOR;
                up     = minc + (frac * span) / HUE_SECTOR;
                down   = minc + ((HUE_SECTOR - frac) * span) / HUE_SECTOR;
                case (sector)
                    hsv2rgb_pkg::SEC_R2Y: begin r = 8'(maxc); g = 8'(up);   b = 8'(minc); end
                    hsv2rgb_pkg::SEC_Y2G: begin r = 8'(down); g = 8'(maxc); b = 8'(minc); end
                    hsv2rgb_pkg::SEC_G2C: begin r = 8'(minc); g = 8'(maxc); b = 8'(up);   end
                    hsv2rgb_pkg::SEC_C2B: begin r = 8'(minc); g = 8'(down); b = 8'(maxc); end
                    hsv2rgb_pkg::SEC_B2M: begin r = 8'(up);   g = 8'(minc); b = 8'(maxc); end
                    default:              begin r = 8'(maxc); g = 8'(minc); b = 8'(down); end
                endcase
                w.color = {r, g, b};
            end
            pending.push_back(w);
        endfunction

        function void check_word(logic [COLOR_W-1:0] color, logic oor);
            t_rgb_word w;
            if (pending.size() == 0) begin
                $error("unexpected word: color %h hue_out_of_range %b", color, oor);
                errors++;
                return;
            end
            w = pending.pop_front();
            if (color !== w.color) begin
                $error("color: expected %h, actual %h", w.color, color);
                errors++;
            end
            if (oor !== w.oor) begin
                $error("hue_out_of_range: expected %b, actual %b", w.oor, oor);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [HUE_W-1:0]   i_hue = '0;
    logic [CHAN_W-1:0]  i_saturation = '0;
    logic [CHAN_W-1:0]  i_brightness = '0;
    logic               o_valid;
    logic [COLOR_W-1:0] o_color;
    logic               o_hue_out_of_range;

    rgb_scoreboard sb = new();
    int            idle_pct = 0;
    int            quiet_cycles = 0;

    hsv_to_rgb_converter dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_hue              (i_hue),
        .i_saturation       (i_saturation),
        .i_brightness       (i_brightness),
        .o_valid            (o_valid),
        .o_color            (o_color),
        .o_hue_out_of_range (o_hue_out_of_range)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_word(o_color, o_hue_out_of_range);
        if (i_rst_n && start && !busy)
            sb.note_pixel(i_hue, i_saturation, i_brightness);
    end

    always @(posedge i_clk) begin
        if ((i_rst_n && start && !busy) || (i_rst_n && o_valid))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("hsv_to_rgb_converter test failed");
            $finish;
        end
    end

    task automatic send_pixel(logic [HUE_W-1:0] hue, logic [CHAN_W-1:0] sat,
                              logic [CHAN_W-1:0] val);
        while ($urandom_range(99) < idle_pct) begin
            start        <= 1'b0;
            i_hue        <= 16'($urandom);
            i_saturation <= 8'($urandom);
            i_brightness <= 8'($urandom);
            @(posedge i_clk);
        end
        start        <= 1'b1;
        i_hue        <= hue;
        i_saturation <= sat;
        i_brightness <= val;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [HUE_W-1:0] pick_hue();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 8)
            return 16'($urandom);
        if (sel < 16)
            return 16'($urandom_range(5) * HUE_SECTOR + $urandom_range(2)
                       + ($urandom_range(1) ? HUE_SECTOR - 3 : 0));
        return 16'($urandom_range(HUE_LIMIT - 1));
    endfunction

    function automatic logic [CHAN_W-1:0] pick_chan();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 6)
            return '0;
        if (sel < 12)
            return '1;
        return 8'($urandom);
    endfunction

    initial begin
        int phase_idle[4];
        phase_idle = '{0, 65, 31, 0};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_pixel(16'd0, 8'd255, 8'd255);
        send_pixel(16'd7679, 8'd255, 8'd255);
        send_pixel(16'd7680, 8'd255, 8'd255);
        send_pixel(16'd15360, 8'd200, 8'd180);
        send_pixel(16'd23040, 8'd255, 8'd255);
        send_pixel(16'd30720, 8'd128, 8'd255);
        send_pixel(16'd38400, 8'd255, 8'd100);
        send_pixel(16'd46079, 8'd255, 8'd255);
        send_pixel(16'd3840, 8'd255, 8'd255);
        send_pixel(16'd11520, 8'd170, 8'd240);
        send_pixel(16'd19200, 8'd90, 8'd255);
        send_pixel(16'd26880, 8'd255, 8'd77);
        send_pixel(16'd34560, 8'd33, 8'd200);
        send_pixel(16'd42240, 8'd255, 8'd255);
        send_pixel(16'd46080, 8'd255, 8'd255);
        send_pixel(16'd65535, 8'd0, 8'd0);
        send_pixel(16'd50000, 8'd127, 8'd99);
        send_pixel(16'd5000, 8'd0, 8'd255);
        send_pixel(16'd20000, 8'd0, 8'd123);
        send_pixel(16'd30000, 8'd255, 8'd0);
        send_pixel(16'd40000, 8'd0, 8'd0);
        send_pixel(16'd45000, 8'd1, 8'd1);
        send_pixel(16'd1, 8'd254, 8'd254);
        send_pixel(16'd32768, 8'd85, 8'd170);
        drain_results();

        foreach (phase_idle[p]) begin
            idle_pct = phase_idle[p];
            repeat (PHASE_LEN)
                send_pixel(pick_hue(), pick_chan(), pick_chan());
            drain_results();
        end

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("hsv_to_rgb_converter test passed");
        else
            $display("hsv_to_rgb_converter test failed");
        $finish;
    end
endmodule

/* files.f */
+incdir+src
src/hsv2rgb_pkg.sv
src/hsv2rgb_span.sv
src/hsv2rgb_ramp.sv
src/hsv_to_rgb_converter.sv
test/tb_hsv_to_rgb_converter.sv
